// ===== hdl/isseq_pkg.sv =====
// Package for the inverter startup sequencer: mode codes, register indexes,
// beat and state structs shared by the step logic, config block and top level.
// No dependencies.
`timescale 1ns / 1ps

package isseq_pkg;

    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 16;
    localparam int TorqueW  = 16;
    localparam int LimitW   = 15;
    localparam int WdW      = 16;
    localparam int NumInv   = 4;

    localparam logic [CfgIdxW-1:0] CFG_TORQUE_LIMIT   = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_WATCHDOG_TICKS = CfgIdxW'(1);

    localparam logic [LimitW-1:0] TORQUE_LIMIT_RST   = LimitW'(2000);
    localparam logic [WdW-1:0]    WATCHDOG_TICKS_RST = WdW'(1000);

    localparam logic [NumInv-1:0] ALL_INV = {NumInv{1'b1}};

    // external mode codes as seen on the result channel
    localparam logic [2:0] CODE_UNDEF   = 3'd0;
    localparam logic [2:0] CODE_IDLE    = 3'd1;
    localparam logic [2:0] CODE_STARTUP = 3'd2;
    localparam logic [2:0] CODE_TORQUE  = 3'd3;
    localparam logic [2:0] CODE_SWOFF   = 3'd4;
    localparam logic [2:0] CODE_ERRRST  = 3'd5;

    typedef enum logic [5:0] {
        MODE_UNDEF   = 6'b000001,
        MODE_IDLE    = 6'b000010,
        MODE_STARTUP = 6'b000100,
        MODE_TORQUE  = 6'b001000,
        MODE_SWOFF   = 6'b010000,
        MODE_ERRRST  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [NumInv-1:0]         error_flags;
        logic [NumInv-1:0]         ready_flags;
        logic [NumInv-1:0]         dc_on_flags;
        logic [NumInv-1:0]         inverter_on_flags;
        logic [NumInv-1:0]         quit_on_flags;
        logic                      ready_to_drive;
        logic signed [TorqueW-1:0] setpoint_fl;
        logic signed [TorqueW-1:0] setpoint_fr;
        logic signed [TorqueW-1:0] setpoint_rl;
        logic signed [TorqueW-1:0] setpoint_rr;
    } in_item_t;

    typedef struct packed {
        logic [LimitW-1:0] torque_limit;
        logic [WdW-1:0]    watchdog_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t                     mode;
        logic                      dc_on;
        logic                      inverter_on;
        logic                      enable;
        logic                      fault_clear;
        logic [LimitW-1:0]         limit;
        logic signed [TorqueW-1:0] target_fl;
        logic signed [TorqueW-1:0] target_fr;
        logic signed [TorqueW-1:0] target_rl;
        logic signed [TorqueW-1:0] target_rr;
        logic [WdW-1:0]            wd_count;
        logic                      wd_armed;
    } state_t;

    typedef struct packed {
        logic [2:0]                mode_out;
        logic                      dc_on_cmd;
        logic                      inverter_on_cmd;
        logic                      enable_cmd;
        logic                      error_reset_cmd;
        logic [LimitW-1:0]         positive_limit;
        logic signed [TorqueW-1:0] target_fl;
        logic signed [TorqueW-1:0] target_fr;
        logic signed [TorqueW-1:0] target_rl;
        logic signed [TorqueW-1:0] target_rr;
        logic                      watchdog_fired;
    } result_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            MODE_UNDEF:   c = CODE_UNDEF;
            MODE_IDLE:    c = CODE_IDLE;
            MODE_STARTUP: c = CODE_STARTUP;
            MODE_TORQUE:  c = CODE_TORQUE;
            MODE_SWOFF:   c = CODE_SWOFF;
            MODE_ERRRST:  c = CODE_ERRRST;
            default:      c = CODE_UNDEF;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/isseq_cfg.sv =====
// Configuration registers of the sequencer: torque limit and watchdog length.
// Depends on isseq_pkg.
`timescale 1ns / 1ps

module isseq_cfg
    import isseq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [CfgIdxW-1:0]  wr_index,
    input  logic [CfgDataW-1:0] wr_data,
    output cfg_t                cfg
);

    logic [LimitW-1:0] torque_limit_reg;
    logic [WdW-1:0]    watchdog_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            torque_limit_reg   <= TORQUE_LIMIT_RST;
            watchdog_ticks_reg <= WATCHDOG_TICKS_RST;
        end else if (wr_en) begin
            // drop writes to indexes beyond the register list
            case (wr_index)
                CFG_TORQUE_LIMIT:   torque_limit_reg   <= wr_data[LimitW-1:0];
                CFG_WATCHDOG_TICKS: watchdog_ticks_reg <= wr_data[WdW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.torque_limit   = torque_limit_reg;
    assign cfg.watchdog_ticks = watchdog_ticks_reg;

endmodule

// ===== hdl/isseq_step.sv =====
// Next-state and result logic for one control tick: watchdog check then the
// mode machine. Purely combinational. Depends on isseq_pkg.
`timescale 1ns / 1ps

module isseq_step
    import isseq_pkg::*;
(
    input  state_t   cur,
    input  in_item_t item,
    input  cfg_t     cfg,
    output state_t   nxt,
    output result_t  res
);

    logic [WdW-1:0] wd_limit;
    logic [WdW-1:0] wd_inc;
    logic           fired;

    assign wd_limit = (cfg.watchdog_ticks == '0) ? WdW'(1) : cfg.watchdog_ticks;
    assign wd_inc   = cur.wd_count + WdW'(1);
    assign fired    = cur.wd_armed && (wd_inc >= wd_limit);

    always_comb begin
        nxt = cur;
        if (cur.wd_armed) begin
            nxt.wd_count = wd_inc;
        end
        if (fired) begin
            nxt.wd_armed = 1'b0;
            nxt.mode     = MODE_UNDEF;
        end else begin
            case (cur.mode)
                MODE_UNDEF: begin
                    // ready on all inverters wins over an error
                    if (item.ready_flags == ALL_INV) begin
                        nxt.mode = MODE_IDLE;
                    end else if (item.error_flags != '0) begin
                        nxt.mode = MODE_ERRRST;
                    end
                end
                MODE_ERRRST: begin
                    if (item.ready_flags == ALL_INV) begin
                        nxt.fault_clear = 1'b0;
                        nxt.mode        = MODE_IDLE;
                    end else begin
                        nxt.fault_clear = 1'b1;
                    end
                end
                MODE_IDLE: begin
                    if (item.ready_to_drive) begin
                        nxt.mode     = MODE_STARTUP;
                        nxt.wd_armed = 1'b1;
                        nxt.wd_count = '0;
                    end
                end
                MODE_STARTUP: begin
                    nxt.dc_on     = 1'b1;
                    nxt.limit     = '0;
                    nxt.target_fl = '0;
                    nxt.target_fr = '0;
                    nxt.target_rl = '0;
                    nxt.target_rr = '0;
                    if (item.dc_on_flags != '0) begin
                        nxt.inverter_on = 1'b1;
                        nxt.enable      = 1'b1;
                        if (item.inverter_on_flags != '0 && item.quit_on_flags == ALL_INV) begin
                            nxt.wd_armed = 1'b0;
                            nxt.mode     = MODE_TORQUE;
                        end
                    end
                end
                MODE_TORQUE: begin
                    nxt.limit     = cfg.torque_limit;
                    nxt.target_fl = item.setpoint_fl;
                    nxt.target_fr = item.setpoint_fr;
                    nxt.target_rl = item.setpoint_rl;
                    nxt.target_rr = item.setpoint_rr;
                    if (item.inverter_on_flags != ALL_INV || !item.ready_to_drive) begin
                        nxt.mode = MODE_SWOFF;
                    end
                end
                MODE_SWOFF: begin
                    nxt.dc_on       = 1'b0;
                    nxt.inverter_on = 1'b0;
                    nxt.enable      = 1'b0;
                    nxt.limit       = '0;
                    nxt.target_fl   = '0;
                    nxt.target_fr   = '0;
                    nxt.target_rl   = '0;
                    nxt.target_rr   = '0;
                    if (!item.inverter_on_flags[0]) begin
                        nxt.mode = MODE_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res.mode_out        = mode_code(nxt.mode);
        res.dc_on_cmd       = nxt.dc_on;
        res.inverter_on_cmd = nxt.inverter_on;
        res.enable_cmd      = nxt.enable;
        res.error_reset_cmd = nxt.fault_clear;
        res.positive_limit  = nxt.limit;
        res.target_fl       = nxt.target_fl;
        res.target_fr       = nxt.target_fr;
        res.target_rl       = nxt.target_rl;
        res.target_rr       = nxt.target_rr;
        res.watchdog_fired  = fired;
    end

endmodule

// ===== hdl/inverter_startup_sequencer.sv =====
// Top level of the inverter startup sequencer: input register, sequencer
// state, result register and handshakes. Depends on isseq_pkg, isseq_cfg
// and isseq_step.
//
// Usage:
//   Each beat on the s_ channel is one control tick carrying the inverter
//   status flags, the ready-to-drive request and four torque setpoints. Each
//   tick yields exactly one beat on the m_ channel with the mode, command
//   bits, torque limit and targets as they stand after the tick.
//   The cfg_ channel writes the torque limit (index 0) and the startup
//   watchdog length (index 1); other indexes are ignored. cfg_ready is
//   always high; write only while no tick is in flight.
//   An accepted tick sits in the input register and is loaded into the
//   result register when that register is free (empty or being taken).
//   Throughput is one tick per cycle while m_ready stays high; the state
//   update is a combinational path from the input register into the state
//   and result registers.
//   When m_ready is low the result register holds, the input register fills,
//   and s_ready drops until the result is taken; nothing is lost.
//   Reset returns the mode to undefined, clears commands, limit, targets and
//   watchdog, and loads the register defaults (limit 2000, watchdog 1000).
`timescale 1ns / 1ps

module inverter_startup_sequencer
    import isseq_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [NumInv-1:0]          s_error_flags,
    input  logic [NumInv-1:0]          s_ready_flags,
    input  logic [NumInv-1:0]          s_dc_on_flags,
    input  logic [NumInv-1:0]          s_inverter_on_flags,
    input  logic [NumInv-1:0]          s_quit_on_flags,
    input  logic                       s_ready_to_drive,
    input  logic signed [TorqueW-1:0]  s_setpoint_fl,
    input  logic signed [TorqueW-1:0]  s_setpoint_fr,
    input  logic signed [TorqueW-1:0]  s_setpoint_rl,
    input  logic signed [TorqueW-1:0]  s_setpoint_rr,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_mode_out,
    output logic                       m_dc_on_cmd,
    output logic                       m_inverter_on_cmd,
    output logic                       m_enable_cmd,
    output logic                       m_error_reset_cmd,
    output logic [LimitW-1:0]          m_positive_limit,
    output logic signed [TorqueW-1:0]  m_target_fl,
    output logic signed [TorqueW-1:0]  m_target_fr,
    output logic signed [TorqueW-1:0]  m_target_rl,
    output logic signed [TorqueW-1:0]  m_target_rr,
    output logic                       m_watchdog_fired,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CfgIdxW-1:0]         cfg_index,
    input  logic [CfgDataW-1:0]        cfg_data
);

    cfg_t     cfg;
    in_item_t item_in;
    in_item_t item_reg;
    logic     in_v_reg;
    state_t   state_reg;
    state_t   state_next;
    result_t  res_next;
    result_t  res_reg;
    logic     out_v_reg;
    logic     out_free;
    logic     advance;

    assign cfg_ready = 1'b1;

    isseq_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign item_in.error_flags       = s_error_flags;
    assign item_in.ready_flags       = s_ready_flags;
    assign item_in.dc_on_flags       = s_dc_on_flags;
    assign item_in.inverter_on_flags = s_inverter_on_flags;
    assign item_in.quit_on_flags     = s_quit_on_flags;
    assign item_in.ready_to_drive    = s_ready_to_drive;
    assign item_in.setpoint_fl       = s_setpoint_fl;
    assign item_in.setpoint_fr       = s_setpoint_fr;
    assign item_in.setpoint_rl       = s_setpoint_rl;
    assign item_in.setpoint_rr       = s_setpoint_rr;

    assign out_free = !out_v_reg || m_ready;
    assign advance  = in_v_reg && out_free;
    assign s_ready  = !in_v_reg || advance;

    isseq_step u_step (
        .cur  (state_reg),
        .item (item_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            state_reg <= '{mode: MODE_UNDEF, default: '0};
        end else begin
            if (s_ready) begin
                in_v_reg <= s_valid;
            end
            if (out_free) begin
                out_v_reg <= in_v_reg;
            end
            // commit the tick only as it moves into the result register
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_in;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = out_v_reg;
    assign m_mode_out        = res_reg.mode_out;
    assign m_dc_on_cmd       = res_reg.dc_on_cmd;
    assign m_inverter_on_cmd = res_reg.inverter_on_cmd;
    assign m_enable_cmd      = res_reg.enable_cmd;
    assign m_error_reset_cmd = res_reg.error_reset_cmd;
    assign m_positive_limit  = res_reg.positive_limit;
    assign m_target_fl       = res_reg.target_fl;
    assign m_target_fr       = res_reg.target_fr;
    assign m_target_rl       = res_reg.target_rl;
    assign m_target_rr       = res_reg.target_rr;
    assign m_watchdog_fired  = res_reg.watchdog_fired;

endmodule

// ===== tb/inverter_startup_sequencer_tb.sv =====
// Self-checking testbench for the inverter startup sequencer: a queue-fed tick driver,
// a stalling result receiver and a tick-level predictor of the mode machine and watchdog.
// Depends on isseq_pkg and the inverter_startup_sequencer top level.
`timescale 1ns / 1ps

module inverter_startup_sequencer_tb;
    import isseq_pkg::*;

    localparam int ItemGoal  = 1650;
    localparam int PhaseLen  = 210;
    localparam int HoldTicks = 400;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic     s_valid = 1'b0;
    logic     s_ready;
    in_item_t drive_item = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [2:0]                m_mode_out;
    logic                      m_dc_on_cmd;
    logic                      m_inverter_on_cmd;
    logic                      m_enable_cmd;
    logic                      m_error_reset_cmd;
    logic [LimitW-1:0]         m_positive_limit;
    logic signed [TorqueW-1:0] m_target_fl;
    logic signed [TorqueW-1:0] m_target_fr;
    logic signed [TorqueW-1:0] m_target_rl;
    logic signed [TorqueW-1:0] m_target_rr;
    logic                      m_watchdog_fired;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;

    // predicted sequencer state and register copies
    logic [2:0]         seq_mode;
    logic               seq_dc_on;
    logic               seq_inv_on;
    logic               seq_enable;
    logic               seq_err_reset;
    logic [LimitW-1:0]  seq_limit;
    logic [TorqueW-1:0] seq_target [NumInv];
    logic [WdW-1:0]     wd_count;
    logic               wd_armed;
    logic [LimitW-1:0]  reg_torque_limit;
    logic [WdW-1:0]     reg_wd_ticks;

    in_item_t tick_queue [$];
    result_t  status_expected [$];

    int pushed_cnt   = 0;
    int accepted_cnt = 0;
    int fail_count   = 0;

    logic s_beat_taken   = 1'b0;
    logic cfg_beat_taken = 1'b0;

    int tx_burst_max = 4;
    int tx_gap_max   = 2;
    int burst_left   = 0;
    int gap_left     = 0;
    int rx_style     = 0;
    int rx_cyc       = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    inverter_startup_sequencer dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_error_flags       (drive_item.error_flags),
        .s_ready_flags       (drive_item.ready_flags),
        .s_dc_on_flags       (drive_item.dc_on_flags),
        .s_inverter_on_flags (drive_item.inverter_on_flags),
        .s_quit_on_flags     (drive_item.quit_on_flags),
        .s_ready_to_drive    (drive_item.ready_to_drive),
        .s_setpoint_fl       (drive_item.setpoint_fl),
        .s_setpoint_fr       (drive_item.setpoint_fr),
        .s_setpoint_rl       (drive_item.setpoint_rl),
        .s_setpoint_rr       (drive_item.setpoint_rr),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_mode_out          (m_mode_out),
        .m_dc_on_cmd         (m_dc_on_cmd),
        .m_inverter_on_cmd   (m_inverter_on_cmd),
        .m_enable_cmd        (m_enable_cmd),
        .m_error_reset_cmd   (m_error_reset_cmd),
        .m_positive_limit    (m_positive_limit),
        .m_target_fl         (m_target_fl),
        .m_target_fr         (m_target_fr),
        .m_target_rl         (m_target_rl),
        .m_target_rr         (m_target_rr),
        .m_watchdog_fired    (m_watchdog_fired),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #1 aclk = ~aclk;

    task automatic note_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic void clear_torque_cmds();
        seq_limit = '0;
        foreach (seq_target[i]) seq_target[i] = '0;
    endfunction

    function automatic result_t advance_sequencer(input in_item_t t);
        result_t    r;
        logic       fired;
        logic [WdW-1:0] wd_len;
        fired = 1'b0;
        if (wd_armed) begin
            wd_len = (reg_wd_ticks == '0) ? WdW'(1) : reg_wd_ticks;
            wd_count = wd_count + 1'b1;
            if (wd_count >= wd_len) begin
                fired    = 1'b1;
                wd_armed = 1'b0;
                seq_mode = CODE_UNDEF;
            end
        end
        if (!fired) begin
            case (seq_mode)
                CODE_UNDEF: begin
                    if (t.error_flags != '0) seq_mode = CODE_ERRRST;
                    if (t.ready_flags == ALL_INV) seq_mode = CODE_IDLE;
                end
                CODE_ERRRST: begin
                    if (t.ready_flags == ALL_INV) begin
                        seq_err_reset = 1'b0;
                        seq_mode      = CODE_IDLE;
                    end else begin
                        seq_err_reset = 1'b1;
                    end
                end
                CODE_IDLE: begin
                    if (t.ready_to_drive) begin
                        seq_mode = CODE_STARTUP;
                        wd_armed = 1'b1;
                        wd_count = '0;
                    end
                end
                CODE_STARTUP: begin
                    seq_dc_on = 1'b1;
                    clear_torque_cmds();
                    if (t.dc_on_flags != '0) begin
                        seq_inv_on = 1'b1;
                        seq_enable = 1'b1;
                        if (t.inverter_on_flags != '0 && t.quit_on_flags == ALL_INV) begin
                            wd_armed = 1'b0;
                            seq_mode = CODE_TORQUE;
                        end
                    end
                end
                CODE_TORQUE: begin
                    if (t.inverter_on_flags != ALL_INV || !t.ready_to_drive) begin
                        seq_mode = CODE_SWOFF;
                    end
                    seq_limit     = reg_torque_limit;
                    seq_target[0] = t.setpoint_fl;
                    seq_target[1] = t.setpoint_fr;
                    seq_target[2] = t.setpoint_rl;
                    seq_target[3] = t.setpoint_rr;
                end
                CODE_SWOFF: begin
                    seq_inv_on = 1'b0;
                    seq_enable = 1'b0;
                    seq_dc_on  = 1'b0;
                    clear_torque_cmds();
                    if (!t.inverter_on_flags[0]) seq_mode = CODE_IDLE;
                end
                default: ;
            endcase
        end
        r.mode_out        = seq_mode;
        r.dc_on_cmd       = seq_dc_on;
        r.inverter_on_cmd = seq_inv_on;
        r.enable_cmd      = seq_enable;
        r.error_reset_cmd = seq_err_reset;
        r.positive_limit  = seq_limit;
        r.target_fl       = seq_target[0];
        r.target_fr       = seq_target[1];
        r.target_rl       = seq_target[2];
        r.target_rr       = seq_target[3];
        r.watchdog_fired  = fired;
        return r;
    endfunction

    // predict on every accepted tick, check every accepted result
    always @(posedge aclk) begin
        result_t want;
        s_beat_taken   <= aresetn && s_valid && s_ready;
        cfg_beat_taken <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TORQUE_LIMIT:   reg_torque_limit = cfg_data[LimitW-1:0];
                    CFG_WATCHDOG_TICKS: reg_wd_ticks     = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                status_expected.push_back(advance_sequencer(drive_item));
                accepted_cnt++;
            end
            if (m_valid && m_ready) begin
                if (status_expected.size() == 0) begin
                    note_mismatch("result beat with no tick outstanding");
                end else begin
                    want = status_expected.pop_front();
                    cmp_field("mode_out", 16'(m_mode_out), 16'(want.mode_out));
                    cmp_field("dc_on_cmd", 16'(m_dc_on_cmd), 16'(want.dc_on_cmd));
                    cmp_field("inverter_on_cmd", 16'(m_inverter_on_cmd),
                              16'(want.inverter_on_cmd));
                    cmp_field("enable_cmd", 16'(m_enable_cmd), 16'(want.enable_cmd));
                    cmp_field("error_reset_cmd", 16'(m_error_reset_cmd),
                              16'(want.error_reset_cmd));
                    cmp_field("positive_limit", 16'(m_positive_limit),
                              16'(want.positive_limit));
                    cmp_field("target_fl", m_target_fl, want.target_fl);
                    cmp_field("target_fr", m_target_fr, want.target_fr);
                    cmp_field("target_rl", m_target_rl, want.target_rl);
                    cmp_field("target_rr", m_target_rr, want.target_rr);
                    cmp_field("watchdog_fired", 16'(m_watchdog_fired),
                              16'(want.watchdog_fired));
                end
            end
        end
    end

    // tick driver: bursts of beats separated by random gaps
    always @(negedge aclk) begin
        if (!(s_valid && !s_beat_taken)) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, tx_burst_max);
                gap_left   = $urandom_range(0, tx_gap_max);
            end
            if (burst_left > 0 && tick_queue.size() > 0) begin
                drive_item <= tick_queue.pop_front();
                s_valid    <= 1'b1;
                burst_left--;
            end else begin
                s_valid <= 1'b0;
                if (burst_left == 0 && gap_left > 0) gap_left--;
            end
        end
    end

    // result receiver: per-phase stall pattern, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HoldTicks;
        end
        rx_cyc++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ((rx_cyc % 5) < 3);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [TorqueW-1:0] rand_torque();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] rand_flags(input int lo, input int hi);
        return 4'($urandom_range(lo, hi));
    endfunction

    task automatic push_full(input logic [3:0] err, input logic [3:0] rdy,
                             input logic [3:0] dcon, input logic [3:0] invon,
                             input logic [3:0] quit, input logic rtd,
                             input logic [15:0] fl, input logic [15:0] fr,
                             input logic [15:0] rl, input logic [15:0] rr);
        in_item_t t;
        t.error_flags       = err;
        t.ready_flags       = rdy;
        t.dc_on_flags       = dcon;
        t.inverter_on_flags = invon;
        t.quit_on_flags     = quit;
        t.ready_to_drive    = rtd;
        t.setpoint_fl       = fl;
        t.setpoint_fr       = fr;
        t.setpoint_rl       = rl;
        t.setpoint_rr       = rr;
        tick_queue.push_back(t);
        pushed_cnt++;
    endtask

    task automatic push_tick(input logic [3:0] err, input logic [3:0] rdy,
                             input logic [3:0] dcon, input logic [3:0] invon,
                             input logic [3:0] quit, input logic rtd);
        push_full(err, rdy, dcon, invon, quit, rtd,
                  rand_torque(), rand_torque(), rand_torque(), rand_torque());
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_beat_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (accepted_cnt != pushed_cnt || status_expected.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // one pass through recovery, idle, startup, torque and switch-off
    task automatic run_drive_cycle();
        int n;
        int k;
        n = $urandom_range(0, 3);
        repeat (n) push_tick(rand_flags(0, 15), rand_flags(0, 14), rand_flags(0, 15),
                             rand_flags(0, 15), rand_flags(0, 15), 1'b0);
        push_tick(rand_flags(0, 15), ALL_INV, rand_flags(0, 15), rand_flags(0, 15),
                  rand_flags(0, 15), 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                             rand_flags(0, 15), rand_flags(0, 15), 1'b0);
        push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                  rand_flags(0, 15), rand_flags(0, 15), 1'b1);
        // incomplete startup ticks let short watchdogs expire
        n = $urandom_range(0, 8);
        repeat (n) begin
            k = $urandom_range(0, 2);
            case (k)
                0: push_tick(rand_flags(0, 15), rand_flags(0, 15), 4'h0,
                             rand_flags(0, 15), rand_flags(0, 15), 1'($urandom));
                1: push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(1, 15),
                             4'h0, rand_flags(0, 15), 1'($urandom));
                default: push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(1, 15),
                                   rand_flags(1, 15), rand_flags(0, 14), 1'($urandom));
            endcase
        end
        push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(1, 15),
                  rand_flags(1, 15), ALL_INV, 1'($urandom));
        n = $urandom_range(1, 16);
        repeat (n) push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                             ALL_INV, rand_flags(0, 15), 1'b1);
        if ($urandom_range(0, 1) == 0) begin
            push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                      rand_flags(0, 15), rand_flags(0, 15), 1'b0);
        end else begin
            push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                      rand_flags(0, 14), rand_flags(0, 15), 1'($urandom));
        end
        n = $urandom_range(0, 3);
        repeat (n) push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                             rand_flags(0, 15) | 4'h1, rand_flags(0, 15), 1'($urandom));
        push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                  rand_flags(0, 15) & 4'hE, rand_flags(0, 15), 1'($urandom));
    endtask

    initial begin
        int phase;
        int goal;
        seq_mode         = CODE_UNDEF;
        seq_dc_on        = 1'b0;
        seq_inv_on       = 1'b0;
        seq_enable       = 1'b0;
        seq_err_reset    = 1'b0;
        clear_torque_cmds();
        wd_count         = '0;
        wd_armed         = 1'b0;
        reg_torque_limit = TORQUE_LIMIT_RST;
        reg_wd_ticks     = WATCHDOG_TICKS_RST;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: ready wins over error in undefined, then a full drive cycle
        push_tick(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0);
        push_tick(ALL_INV, ALL_INV, 4'h0, 4'h0, 4'h0, 1'b0);
        push_tick(ALL_INV, ALL_INV, ALL_INV, ALL_INV, ALL_INV, 1'b0);
        push_tick(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b1);
        push_tick(4'h0, 4'h0, 4'h0, ALL_INV, ALL_INV, 1'b1);
        push_tick(4'h0, 4'h0, 4'h1, 4'h0, ALL_INV, 1'b1);
        push_tick(4'h0, 4'h0, ALL_INV, 4'h2, 4'h7, 1'b1);
        push_tick(4'h0, 4'h0, ALL_INV, ALL_INV, ALL_INV, 1'b1);
        push_full(4'h0, 4'h0, 4'h0, ALL_INV, 4'h0, 1'b1,
                  16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
        push_full(ALL_INV, ALL_INV, ALL_INV, ALL_INV, ALL_INV, 1'b1,
                  16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
        push_tick(4'h0, 4'h0, 4'h0, 4'h7, 4'h0, 1'b1);
        push_tick(4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 1'b0);
        push_tick(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0);
        push_tick(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b1);
        push_tick(4'h0, 4'h0, 4'h8, 4'h8, ALL_INV, 1'b0);
        push_tick(4'h0, 4'h0, 4'h0, ALL_INV, 4'h0, 1'b0);
        push_tick(4'h0, 4'h0, 4'h0, 4'hE, 4'h0, 1'b0);
        wait_idle();

        // directed: watchdog expiry keeps the commands, then error reset recovery
        write_reg(CFG_WATCHDOG_TICKS, 16'd2);
        write_reg(CfgIdxW'(4'hF), 16'hFFFF);
        push_tick(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b1);
        push_tick(4'h0, 4'h0, ALL_INV, 4'h0, 4'h0, 1'b1);
        push_tick(4'h0, 4'h0, ALL_INV, ALL_INV, ALL_INV, 1'b1);
        push_tick(4'h3, 4'h7, 4'h0, 4'h0, 4'h0, 1'b0);
        push_tick(4'h0, 4'h5, 4'h0, 4'h0, 4'h0, 1'b0);
        push_tick(4'h0, ALL_INV, 4'h0, 4'h0, 4'h0, 1'b0);
        wait_idle();

        phase = 0;
        while (pushed_cnt < ItemGoal) begin
            case (phase)
                0: begin
                    write_reg(CFG_TORQUE_LIMIT, 16'h7FFF);
                    write_reg(CFG_WATCHDOG_TICKS, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_TORQUE_LIMIT, 16'h0000);
                    write_reg(CFG_WATCHDOG_TICKS, 16'd1);
                end
                2: begin
                    // top data bit is beyond the limit register and must drop
                    write_reg(CFG_TORQUE_LIMIT, 16'($urandom) | 16'h8000);
                    write_reg(CFG_WATCHDOG_TICKS, 16'd0);
                end
                3: begin
                    write_reg(CFG_TORQUE_LIMIT, 16'($urandom));
                    write_reg(CFG_WATCHDOG_TICKS, 16'($urandom_range(2, 12)));
                    write_reg(CfgIdxW'($urandom_range(2, 15)), 16'($urandom));
                end
                default: begin
                    write_reg(CFG_TORQUE_LIMIT, 16'($urandom_range(0, 32767)));
                    if ($urandom_range(0, 1) == 0) begin
                        write_reg(CFG_WATCHDOG_TICKS, 16'($urandom_range(1, 20)));
                    end else begin
                        write_reg(CFG_WATCHDOG_TICKS, 16'($urandom));
                    end
                end
            endcase
            case (phase % 4)
                0: begin tx_burst_max = 64; tx_gap_max = 0; end
                1: begin tx_burst_max = 8;  tx_gap_max = 3; end
                2: begin tx_burst_max = 3;  tx_gap_max = 6; end
                default: begin tx_burst_max = 16; tx_gap_max = 1; end
            endcase
            rx_style = (phase * 3) % 4;
            goal = pushed_cnt + PhaseLen;
            while (pushed_cnt < goal) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 6))
                        push_tick(rand_flags(0, 15), rand_flags(0, 15), rand_flags(0, 15),
                                  rand_flags(0, 15), rand_flags(0, 15), 1'($urandom));
                end else begin
                    run_drive_cycle();
                end
            end
            // stall the result side long enough to back up the input
            if (phase == 1 || phase == 5) hold_asked++;
            wait_idle();
            phase++;
        end

        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
